/* rtl/irpd_pkg.sv */
// Shared types and constants for the infrared pulse-distance transmitter.
// No dependencies; the design files refer to this package by scoped names, the testbench imports it.
package irpd_pkg;

  // payload geometry
  localparam int unsigned MAX_BITS  = 64;
  localparam int unsigned COUNT_W   = $clog2(MAX_BITS + 1);
  localparam int unsigned BIT_IDX_W = $clog2(MAX_BITS);

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_MARK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARK         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_ZERO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_ONE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HALF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TOTAL = 3'd6;

  // register reset values
  localparam logic [15:0] RST_START_MARK   = 16'd2200;
  localparam logic [15:0] RST_MARK         = 16'd750;
  localparam logic [15:0] RST_SPACE_ZERO   = 16'd750;
  localparam logic [15:0] RST_SPACE_ONE    = 16'd1500;
  localparam logic [7:0]  RST_CARRIER_HALF = 8'd13;
  localparam logic [19:0] RST_REPEAT_GAP   = 20'd100000;
  localparam logic [3:0]  RST_REPEAT_TOTAL = 4'd2;

  // input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  typedef struct packed {
    logic                command;
    logic [63:0]         payload;
    logic [COUNT_W-1:0]  bit_count;
  } in_item_t;

  typedef struct packed {
    logic        ir_level;
    logic        busy_res;
    logic        done_res;
    logic        rejected;
    logic [31:0] sent_total;
  } out_item_t;

  // classified item handed from front to back
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SEND = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [MAX_BITS-1:0]   payload;
    logic [COUNT_W-1:0]    bit_count;
  } op_t;

endpackage

/* rtl/irpd_front.sv */
// Front stage: accepts input items, decodes the command and saturates the bit count.
// Depends on irpd_pkg; feeds irpd_queue.
module irpd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  irpd_pkg::in_item_t in_item,
  output logic               op_valid,
  input  logic               op_ready,
  output irpd_pkg::op_t      op
);

  logic          held;
  irpd_pkg::op_t held_op;
  irpd_pkg::op_t op_next;

  // classify the incoming item
  always_comb begin
    op_next.kind    = (in_item.command == irpd_pkg::CMD_SEND) ? irpd_pkg::OP_SEND
                                                              : irpd_pkg::OP_TICK;
    op_next.payload = in_item.payload[irpd_pkg::MAX_BITS-1:0];
    if (in_item.bit_count > irpd_pkg::COUNT_W'(irpd_pkg::MAX_BITS)) begin
      op_next.bit_count = irpd_pkg::COUNT_W'(irpd_pkg::MAX_BITS);
    end else begin
      op_next.bit_count = in_item.bit_count;
    end
  end

  assign in_ready = !held || op_ready;
  assign op_valid = held;
  assign op       = held_op;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_op <= op_next;
    end
  end

endmodule

/* rtl/irpd_queue.sv */
// Two-entry queue between front and back so that each side stalls on its own.
// Depends on irpd_pkg for the item type.
module irpd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  irpd_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output irpd_pkg::op_t pop_op
);

  irpd_pkg::op_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_op     = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

/* rtl/irpd_back.sv */
// Back end: configuration registers, transmit sequencer and output register.
// Depends on irpd_pkg; consumes items from irpd_queue.
module irpd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                op_valid,
  output logic                                op_ready,
  input  irpd_pkg::op_t                       op,
  output logic                                out_valid,
  input  logic                                out_ready,
  output irpd_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_SPACE = 5'b00100,
    PH_MARK  = 5'b01000,
    PH_GAP   = 5'b10000
  } phase_t;

  // configuration
  logic [15:0] start_mark_ticks;
  logic [15:0] mark_ticks;
  logic [15:0] space_zero_ticks;
  logic [15:0] space_one_ticks;
  logic [7:0]  carrier_half_ticks;
  logic [19:0] repeat_gap_ticks;
  logic [3:0]  repeat_total;

  // sequencer state
  phase_t                           phase, phase_next;
  logic [19:0]                      ticks_left, ticks_left_next;
  logic [7:0]                       carrier_count, carrier_count_next;
  logic                             carrier_level, carrier_level_next;
  logic [irpd_pkg::MAX_BITS-1:0]    shift_bits, shift_bits_next;
  logic [irpd_pkg::COUNT_W-1:0]     packet_bits, packet_bits_next;
  logic [irpd_pkg::COUNT_W-1:0]     bits_left, bits_left_next;
  logic [3:0]                       repeats_left, repeats_left_next;
  logic [31:0]                      sent_counter, sent_counter_next;

  logic                             pop;
  irpd_pkg::out_item_t              res;
  logic [irpd_pkg::COUNT_W-1:0]     bits_dec;
  logic [irpd_pkg::COUNT_W-1:0]     space_bits;
  logic [irpd_pkg::COUNT_W-1:0]     space_pos;
  logic [irpd_pkg::BIT_IDX_W-1:0]   space_idx;
  logic [15:0]                      space_raw;
  logic [19:0]                      space_len;
  logic [19:0]                      start_len;
  logic [19:0]                      mark_len;
  logic [19:0]                      ticks_dec;
  logic [7:0]                       count_inc;
  logic [3:0]                       reps_dec;
  logic                             do_space;
  logic                             do_end;
  logic                             do_packet;

  function automatic logic [19:0] at_least_one(input logic [15:0] v);
    logic [19:0] r;
    r = (v == 16'd0) ? 20'd1 : {4'd0, v};
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign pop       = op_valid && (!out_valid || out_ready);
  assign op_ready  = !out_valid || out_ready;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      start_mark_ticks   <= irpd_pkg::RST_START_MARK;
      mark_ticks         <= irpd_pkg::RST_MARK;
      space_zero_ticks   <= irpd_pkg::RST_SPACE_ZERO;
      space_one_ticks    <= irpd_pkg::RST_SPACE_ONE;
      carrier_half_ticks <= irpd_pkg::RST_CARRIER_HALF;
      repeat_gap_ticks   <= irpd_pkg::RST_REPEAT_GAP;
      repeat_total       <= irpd_pkg::RST_REPEAT_TOTAL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        irpd_pkg::REG_START_MARK:   start_mark_ticks   <= cfg_data[15:0];
        irpd_pkg::REG_MARK:         mark_ticks         <= cfg_data[15:0];
        irpd_pkg::REG_SPACE_ZERO:   space_zero_ticks   <= cfg_data[15:0];
        irpd_pkg::REG_SPACE_ONE:    space_one_ticks    <= cfg_data[15:0];
        irpd_pkg::REG_CARRIER_HALF: carrier_half_ticks <= cfg_data[7:0];
        irpd_pkg::REG_REPEAT_GAP:   repeat_gap_ticks   <= cfg_data[19:0];
        irpd_pkg::REG_REPEAT_TOTAL: repeat_total       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // shared arithmetic for the step
  always_comb begin
    bits_dec   = bits_left - irpd_pkg::COUNT_W'(1);
    space_bits = (phase == PH_MARK) ? bits_dec : bits_left;
    space_pos  = space_bits - irpd_pkg::COUNT_W'(1);
    space_idx  = space_pos[irpd_pkg::BIT_IDX_W-1:0];
    space_raw  = shift_bits[space_idx] ? space_one_ticks : space_zero_ticks;
    space_len  = at_least_one(space_raw);
    start_len  = at_least_one(start_mark_ticks);
    mark_len   = at_least_one(mark_ticks);
    ticks_dec  = ticks_left - 20'd1;
    count_inc  = carrier_count + 8'd1;
    reps_dec   = repeats_left - 4'd1;
  end

  // one step of the sequencer per popped item
  always_comb begin
    phase_next         = phase;
    ticks_left_next    = ticks_left;
    carrier_count_next = carrier_count;
    carrier_level_next = carrier_level;
    shift_bits_next    = shift_bits;
    packet_bits_next   = packet_bits;
    bits_left_next     = bits_left;
    repeats_left_next  = repeats_left;
    sent_counter_next  = sent_counter;
    do_space           = 1'b0;
    do_end             = 1'b0;
    do_packet          = 1'b0;
    res                = '0;

    if (pop) begin
      if (op.kind == irpd_pkg::OP_SEND) begin
        res.busy_res = 1'b1;
        if (phase != PH_IDLE) begin
          res.rejected = 1'b1;
        end else begin
          shift_bits_next    = op.payload;
          packet_bits_next   = op.bit_count;
          bits_left_next     = op.bit_count;
          repeats_left_next  = (repeat_total == 4'd0) ? 4'd1 : repeat_total;
          phase_next         = PH_START;
          ticks_left_next    = start_len;
          carrier_count_next = 8'd0;
          carrier_level_next = 1'b0;
        end
      end else if (phase != PH_IDLE) begin
        res.busy_res = 1'b1;
        // carrier during marks
        if (phase == PH_START || phase == PH_MARK) begin
          res.ir_level = carrier_level;
          if (count_inc == carrier_half_ticks) begin
            carrier_level_next = ~carrier_level;
            carrier_count_next = 8'd0;
          end else begin
            carrier_count_next = count_inc;
          end
        end
        ticks_left_next = ticks_dec;
        // phase change when the count runs out
        if (ticks_dec == 20'd0) begin
          unique case (phase)
            PH_START: begin
              if (bits_left != '0) begin
                do_space = 1'b1;
              end else begin
                do_end = 1'b1;
              end
            end
            PH_SPACE: begin
              phase_next         = PH_MARK;
              ticks_left_next    = mark_len;
              carrier_count_next = 8'd0;
              carrier_level_next = 1'b0;
            end
            PH_MARK: begin
              bits_left_next = bits_dec;
              if (bits_dec != '0) begin
                do_space = 1'b1;
              end else begin
                do_end = 1'b1;
              end
            end
            default: do_packet = 1'b1;
          endcase
        end

        if (do_space) begin
          phase_next      = PH_SPACE;
          ticks_left_next = space_len;
        end

        // end of one packet
        if (do_end) begin
          repeats_left_next = reps_dec;
          if (reps_dec == 4'd0) begin
            phase_next        = PH_IDLE;
            ticks_left_next   = 20'd0;
            sent_counter_next = sent_counter + 32'd1;
            res.done_res      = 1'b1;
          end else if (repeat_gap_ticks == 20'd0) begin
            do_packet = 1'b1;
          end else begin
            phase_next      = PH_GAP;
            ticks_left_next = repeat_gap_ticks;
          end
        end

        if (do_packet) begin
          bits_left_next     = packet_bits;
          phase_next         = PH_START;
          ticks_left_next    = start_len;
          carrier_count_next = 8'd0;
          carrier_level_next = 1'b0;
        end
      end
    end
    res.sent_total = sent_counter_next;
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      ticks_left    <= 20'd0;
      carrier_count <= 8'd0;
      carrier_level <= 1'b0;
      shift_bits    <= '0;
      packet_bits   <= '0;
      bits_left     <= '0;
      repeats_left  <= 4'd0;
      sent_counter  <= 32'd0;
    end else begin
      phase         <= phase_next;
      ticks_left    <= ticks_left_next;
      carrier_count <= carrier_count_next;
      carrier_level <= carrier_level_next;
      shift_bits    <= shift_bits_next;
      packet_bits   <= packet_bits_next;
      bits_left     <= bits_left_next;
      repeats_left  <= repeats_left_next;
      sent_counter  <= sent_counter_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op_ready) begin
      out_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= res;
    end
  end

endmodule

/* rtl/ir_pulse_distance_transmitter_top.sv */
// Infrared pulse-distance transmitter, one result item per input item.
// Path: input item to front holding register, queue entry, then back output register.
// Throughput: one item per cycle while out_ready allows; one sequencer step per item.
// Reset: synchronous, clears the queue and sequencer and loads register defaults.
// Depends on irpd_pkg, irpd_front, irpd_queue and irpd_back.
module ir_pulse_distance_transmitter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  irpd_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output irpd_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic          f_valid;
  logic          f_ready;
  irpd_pkg::op_t f_op;
  logic          q_valid;
  logic          q_ready;
  irpd_pkg::op_t q_op;

  // decode stage
  irpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  // decoupling queue
  irpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  // sequencer
  irpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op        (q_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* rtl/irpd_checker.sv */
// Port-level checks for the transmitter, attached to the top level by bind.
// Depends on irpd_pkg and ir_pulse_distance_transmitter_top.
module irpd_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input irpd_pkg::out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // a rejected send is always reported busy
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.rejected |-> out_item.busy_res)
    else $error("rejected without busy");

  // the carrier only shows during a transmission
  a_level_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.ir_level |-> out_item.busy_res && !out_item.rejected)
    else $error("emitter on outside a transmission");

  // completion belongs to a tick of a running transmission
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> out_item.busy_res && !out_item.rejected)
    else $error("done without busy");

endmodule

bind ir_pulse_distance_transmitter_top irpd_checker u_irpd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

/* tb/tb_ir_pulse_distance_transmitter_top.sv */
// Self-checking testbench for the infrared pulse-distance transmitter top level.
// Drives ticks and send items with random idling and checks every result item.
// Depends on irpd_pkg and ir_pulse_distance_transmitter_top.
module tb_ir_pulse_distance_transmitter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import irpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned DRAIN_CHUNK  = 32;
  localparam int unsigned PRINT_CAP    = 30;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [COUNT_W-1:0]   BITS_CAP   = COUNT_W'(MAX_BITS);

  typedef enum logic [2:0] {
    TX_IDLE, TX_START, TX_SPACE, TX_MARK, TX_GAP
  } tx_phase_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // handshake flags seen at the last rising edge
  logic in_accepted = 1'b0;
  logic out_accepted = 1'b0;
  logic calm_mode = 1'b0;
  logic pressure_done = 1'b0;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned items_queued = 0;
  int unsigned cfg_writes = 0;
  int unsigned sends_started = 0;
  int unsigned sends_rejected = 0;
  int unsigned transmissions_done = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_left = 0;

  // predicted register contents
  logic [15:0] start_len   = RST_START_MARK;
  logic [15:0] mark_len    = RST_MARK;
  logic [15:0] zero_len    = RST_SPACE_ZERO;
  logic [15:0] one_len     = RST_SPACE_ONE;
  logic [7:0]  half_period = RST_CARRIER_HALF;
  logic [19:0] gap_len     = RST_REPEAT_GAP;
  logic [3:0]  repeat_cfg  = RST_REPEAT_TOTAL;

  // predicted sequencer state
  tx_phase_t    tx_phase      = TX_IDLE;
  logic [19:0]  ticks_left    = '0;
  logic [7:0]   carrier_cnt   = '0;
  logic         carrier_lvl   = 1'b0;
  logic [63:0]  shift_reg     = '0;
  logic [6:0]   packet_len    = '0;
  logic [6:0]   bits_to_go    = '0;
  logic [3:0]   repeats_to_go = '0;
  logic [31:0]  sent_count    = '0;

  ir_pulse_distance_transmitter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transmitter predictor
  function automatic logic [19:0] at_least_one_tick(input logic [19:0] len);
    return (len == 20'd0) ? 20'd1 : len;
  endfunction

  function automatic void open_mark(input tx_phase_t ph, input logic [15:0] len);
    tx_phase = ph;
    ticks_left = at_least_one_tick({4'd0, len});
    carrier_cnt = '0;
    carrier_lvl = 1'b0;
  endfunction

  function automatic void open_packet();
    bits_to_go = packet_len;
    open_mark(TX_START, start_len);
  endfunction

  function automatic void open_space();
    logic [6:0] bit_pos;
    bit_pos = bits_to_go - 7'd1;
    tx_phase = TX_SPACE;
    ticks_left = at_least_one_tick({4'd0, shift_reg[bit_pos[5:0]] ? one_len : zero_len});
  endfunction

  // returns high when the last repeat has gone out
  function automatic logic close_packet();
    repeats_to_go = repeats_to_go - 4'd1;
    if (repeats_to_go == 4'd0) begin
      tx_phase = TX_IDLE;
      ticks_left = '0;
      sent_count = sent_count + 32'd1;
      return 1'b1;
    end
    if (gap_len == 20'd0) begin
      open_packet();
    end else begin
      tx_phase = TX_GAP;
      ticks_left = gap_len;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t step_transmitter(input in_item_t it);
    out_item_t res;
    res = '0;
    if (it.command == CMD_SEND) begin
      res.busy_res = 1'b1;
      if (tx_phase != TX_IDLE) begin
        res.rejected = 1'b1;
        sends_rejected++;
      end else begin
        shift_reg = it.payload;
        packet_len = (it.bit_count > BITS_CAP) ? BITS_CAP : it.bit_count;
        repeats_to_go = (repeat_cfg == 4'd0) ? 4'd1 : repeat_cfg;
        open_packet();
        sends_started++;
      end
    end else if (tx_phase != TX_IDLE) begin
      res.busy_res = 1'b1;
      // carrier only during marks, toggling after a half period
      if (tx_phase == TX_START || tx_phase == TX_MARK) begin
        res.ir_level = carrier_lvl;
        carrier_cnt = carrier_cnt + 8'd1;
        if (carrier_cnt == half_period) begin
          carrier_lvl = ~carrier_lvl;
          carrier_cnt = '0;
        end
      end
      ticks_left = ticks_left - 20'd1;
      if (ticks_left == 20'd0) begin
        case (tx_phase)
          TX_START: begin
            if (bits_to_go != 7'd0) open_space();
            else res.done_res = close_packet();
          end
          TX_SPACE: begin
            open_mark(TX_MARK, mark_len);
          end
          TX_MARK: begin
            bits_to_go = bits_to_go - 7'd1;
            if (bits_to_go != 7'd0) open_space();
            else res.done_res = close_packet();
          end
          default: begin
            open_packet();
          end
        endcase
      end
    end
    res.sent_total = sent_count;
    if (res.done_res) transmissions_done++;
    return res;
  endfunction

  function automatic int unsigned draw_wait();
    return calm_mode ? 0 : $urandom_range(0, 4);
  endfunction

  // register value with random bits above the register width
  function automatic logic [CFG_DATA_W-1:0] with_junk(input int unsigned val,
                                                      input int unsigned width);
    logic [CFG_DATA_W-1:0] noise;
    noise = CFG_DATA_W'($urandom());
    return (noise << width) | val[CFG_DATA_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at result %0d: %s got %0h expected %0h",
               results_checked, what, got, want);
    mismatch_count++;
  endtask

  // input driver, one item per handshake
  always @(negedge clk) begin : item_driver
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else if (!in_valid || in_accepted) begin
      if (in_valid) send_wait = draw_wait();
      if (send_wait != 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure, with one long hold-off
  always @(negedge clk) begin : result_ready
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_accepted) recv_wait = draw_wait();
      // hold off while the sender still has plenty to offer
      if (!pressure_done && pending_items.size() >= 16) begin
        hold_left = 300;
        pressure_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // prediction on acceptance, comparison on each result item
  always @(posedge clk) begin : result_check
    out_item_t want;
    in_accepted <= in_valid && in_ready;
    out_accepted <= out_valid && out_ready;
    if (!rst) begin
      if (in_valid && in_ready) expected_results.push_back(step_transmitter(in_item));
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", 64'(out_item), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.ir_level !== want.ir_level)
            report_mismatch("ir_level", 64'(out_item.ir_level), 64'(want.ir_level));
          if (out_item.busy_res !== want.busy_res)
            report_mismatch("busy_res", 64'(out_item.busy_res), 64'(want.busy_res));
          if (out_item.done_res !== want.done_res)
            report_mismatch("done_res", 64'(out_item.done_res), 64'(want.done_res));
          if (out_item.rejected !== want.rejected)
            report_mismatch("rejected", 64'(out_item.rejected), 64'(want.rejected));
          if (out_item.sent_total !== want.sent_total)
            report_mismatch("sent_total", 64'(out_item.sent_total),
                            64'(want.sent_total));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_ir_pulse_distance_transmitter_top failed");
      $finish;
    end
  end

  task automatic queue_send(input logic [63:0] bits, input logic [6:0] count);
    in_item_t it;
    it.command = CMD_SEND;
    it.payload = bits;
    it.bit_count = count;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // tick items carry random payload and count, which must be ignored
  task automatic queue_ticks(input int unsigned n);
    in_item_t it;
    repeat (n) begin
      it.command = CMD_TICK;
      it.payload = {$urandom(), $urandom()};
      it.bit_count = COUNT_W'($urandom());
      pending_items.push_back(it);
      items_queued++;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // tick until the predicted transmission is over
  task automatic run_until_idle();
    wait_drained();
    while (tx_phase != TX_IDLE) begin
      queue_ticks(DRAIN_CHUNK);
      wait_drained();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_START_MARK:   start_len = value[15:0];
      REG_MARK:         mark_len = value[15:0];
      REG_SPACE_ZERO:   zero_len = value[15:0];
      REG_SPACE_ONE:    one_len = value[15:0];
      REG_CARRIER_HALF: half_period = value[7:0];
      REG_REPEAT_GAP:   gap_len = value[19:0];
      REG_REPEAT_TOTAL: repeat_cfg = value[3:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_timing(input logic [CFG_DATA_W-1:0] start_v, mark_v, zero_v, one_v,
                             half_v, gap_v, reps_v);
    write_reg(REG_START_MARK, start_v);
    write_reg(REG_MARK, mark_v);
    write_reg(REG_SPACE_ZERO, zero_v);
    write_reg(REG_SPACE_ONE, one_v);
    write_reg(REG_CARRIER_HALF, half_v);
    write_reg(REG_REPEAT_GAP, gap_v);
    write_reg(REG_REPEAT_TOTAL, reps_v);
  endtask

  initial begin : stimulus
    int unsigned random_start;
    int unsigned bits;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset carrier half period, short start mark, one repeat, a refused send
    queue_ticks(3);
    wait_drained();
    write_reg(REG_START_MARK, 20'd30);
    write_reg(REG_REPEAT_TOTAL, 20'd1);
    queue_send(64'h1, 7'd0);
    queue_ticks(10);
    queue_send(64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
    run_until_idle();

    // short timing, field extremes and a refused send
    load_timing(20'd3, 20'd2, 20'd1, 20'd2, 20'd1, 20'd2, 20'd2);
    queue_send(64'hA5, 7'd8);
    queue_ticks(2);
    queue_send(64'h0, 7'd0);
    run_until_idle();
    // empty packet, start mark only
    queue_send(64'h0, 7'd0);
    run_until_idle();
    // widest packets sent once each
    write_reg(REG_REPEAT_TOTAL, 20'd1);
    queue_send(64'h8000_0000_0000_0001, 7'd64);
    run_until_idle();
    // bit count above the maximum is clipped
    queue_send({$urandom(), $urandom()}, 7'd127);
    run_until_idle();

    // zero lengths last one tick, zero gap restarts straight away
    load_timing(20'd0, 20'd0, 20'd0, 20'd0, 20'd1, 20'd0, 20'd3);
    queue_send(64'h5555_5555_5555_5555, 7'd16);
    run_until_idle();
    // zero repeat count behaves as one
    load_timing(20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd5, 20'd0);
    queue_send(64'h3, 7'd2);
    run_until_idle();
    load_timing(20'd2, 20'd1, 20'd1, 20'd2, 20'd2, 20'd1, 20'd15);
    queue_send(64'hB, 7'd4);
    run_until_idle();

    // zero carrier half toggles every 256 ticks, then the largest half
    load_timing(20'd260, 20'd1, 20'd1, 20'd1, 20'd0, 20'd1, 20'd1);
    queue_send(64'h0, 7'd0);
    run_until_idle();
    write_reg(REG_CARRIER_HALF, 20'd255);
    queue_send(64'h0, 7'd0);
    run_until_idle();

    // unused index must change nothing
    write_reg(REG_UNUSED, 20'hFFFFF);
    queue_send(64'h2, 7'd2);
    run_until_idle();

    // junk above each narrower register width, largest gap with a single repeat
    calm_mode = 1'b1;
    load_timing(20'hF0040, 20'hF0001, 20'hF0001, 20'hF0001, 20'hFFF05, 20'hFFFFF, 20'hFFFF1);
    queue_send(64'h0, 7'd0);
    run_until_idle();

    // random phases: fresh timing, then sends with random spacing
    random_start = items_queued;
    while (items_queued - random_start < RANDOM_ITEMS) begin
      calm_mode = ($urandom_range(0, 3) == 0);
      load_timing(with_junk($urandom_range(0, 8), 16), with_junk($urandom_range(0, 4), 16),
                  with_junk($urandom_range(0, 6), 16), with_junk($urandom_range(0, 6), 16),
                  with_junk($urandom_range(0, 5), 8), CFG_DATA_W'($urandom_range(0, 10)),
                  with_junk(($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 3), 4));
      repeat ($urandom_range(2, 6)) begin
        bits = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 127) : $urandom_range(0, 8);
        queue_send({$urandom(), $urandom()}, bits[6:0]);
        // a second send soon after, mostly refused
        if ($urandom_range(0, 3) == 0) begin
          queue_ticks($urandom_range(0, 10));
          queue_send({$urandom(), $urandom()}, 7'($urandom()));
        end
        queue_ticks($urandom_range(1, 100));
      end
      run_until_idle();
    end

    calm_mode = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("items never returned", 64'(expected_results.size()), '0);
    $display("run: %0d items, %0d transmissions started, %0d sends refused, %0d completed",
             items_queued, sends_started, sends_rejected, transmissions_done);
    $display("run: %0d register writes, %0d result items compared, %0d mismatches",
             cfg_writes, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_ir_pulse_distance_transmitter_top passed");
    end else begin
      $display("tb_ir_pulse_distance_transmitter_top failed");
    end
    $finish;
  end

endmodule
